/* src/csc_pkg.sv */
// Shared types and constants for the climate sensor compensation block.
// Used by csc_div and climate_sensor_compensation; depends on nothing.
package csc_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 64;

  localparam logic [CfgIndexW-1:0] CFG_TEMP_CALIB    = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_PRESS_CALIB_A = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_PRESS_CALIB_B = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_PRESS_CALIB_C = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_HUM_CALIB_A   = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_HUM_CALIB_B   = 3'd5;

  localparam int DivW       = 64;
  localparam int DivLatency = DivW + 2;
  localparam int PreStages  = 11;
  localparam int PostStages = 10;
  localparam int PipeLatency = PreStages + DivLatency + PostStages;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic [16:0]        humidity_q22_10;
  } out_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic signed [31:0] hum_h;
    logic [15:0]        raw_humidity;
  } side_t;

endpackage

/* src/csc_div.sv */
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Carries a side payload alongside; depends on csc_pkg.
module csc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [63:0]       num,
  input  logic signed [63:0]       den,
  input  csc_pkg::side_t           side_in,
  output logic                     out_valid,
  output logic signed [63:0]       quot,
  output logic                     zero,
  output csc_pkg::side_t           side_out
);

  logic [63:0]          n  [0:csc_pkg::DivW];
  logic [63:0]          r  [0:csc_pkg::DivW];
  logic [63:0]          d  [0:csc_pkg::DivW];
  logic                 ng [0:csc_pkg::DivW];
  logic                 z  [0:csc_pkg::DivW];
  csc_pkg::side_t       sd [0:csc_pkg::DivW];
  logic [csc_pkg::DivW:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    n[0]  <= num[63] ? 64'(-num) : num;
    d[0]  <= den[63] ? 64'(-den) : den;
    r[0]  <= '0;
    ng[0] <= num[63] ^ den[63];
    z[0]  <= (den == '0);
    sd[0] <= side_in;
  end

  for (genvar i = 0; i < csc_pkg::DivW; i++) begin : g_step
    logic [64:0] t;
    logic        ge;
    logic [64:0] diff;
    assign t    = {r[i], n[i][63]};
    assign diff = t - {1'b0, d[i]};
    assign ge   = (t >= {1'b0, d[i]});
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      r[i+1]  <= ge ? diff[63:0] : t[63:0];
      n[i+1]  <= {n[i][62:0], ge};
      d[i+1]  <= d[i];
      ng[i+1] <= ng[i];
      z[i+1]  <= z[i];
      sd[i+1] <= sd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[csc_pkg::DivW];
    end
    quot     <= ng[csc_pkg::DivW] ? $signed(-n[csc_pkg::DivW]) : $signed(n[csc_pkg::DivW]);
    zero     <= z[csc_pkg::DivW];
    side_out <= sd[csc_pkg::DivW];
  end

  assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##(csc_pkg::DivLatency) out_valid)
    else $error("divider lost a transfer");

endmodule

/* src/climate_sensor_compensation.sv */
// Top level of the climate sensor compensation pipeline.
// Depends on csc_pkg and csc_div.
//
// Usage: calibration words are written through cfg_write, cfg_index and
// cfg_data while the pipeline is empty. A raw reading on sample is taken at
// every rising edge with start high; busy is always low, so a new reading
// may enter in every cycle. Each reading gives one result on result, marked
// by done for exactly one cycle. Throughput is one reading per cycle. The
// pipeline is built around the 66-stage pipelined pressure divider (an
// input register, 64 quotient steps and an output register), with eleven
// stages before it and ten after it. Reset clears the calibration
// registers and the valid bits that carry done, but not pressure_valid.
// The receiver cannot stall the pipeline, so each result must be taken in
// the cycle in which done is high.
module climate_sensor_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [csc_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [csc_pkg::CfgDataW-1:0]       cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  csc_pkg::in_t                       sample,
  output logic                               done,
  output csc_pkg::out_t                      result
);

  logic [47:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [15:0] press_calib_c;
  logic [31:0] hum_calib_a;
  logic [31:0] hum_calib_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
      hum_calib_a   <= '0;
      hum_calib_b   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        csc_pkg::CFG_TEMP_CALIB:    temp_calib    <= cfg_data[47:0];
        csc_pkg::CFG_PRESS_CALIB_A: press_calib_a <= cfg_data;
        csc_pkg::CFG_PRESS_CALIB_B: press_calib_b <= cfg_data;
        csc_pkg::CFG_PRESS_CALIB_C: press_calib_c <= cfg_data[15:0];
        csc_pkg::CFG_HUM_CALIB_A:   hum_calib_a   <= cfg_data[31:0];
        csc_pkg::CFG_HUM_CALIB_B:   hum_calib_b   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [16:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [8:0]         h1, h3;
  logic signed [15:0] h2;
  logic signed [31:0] h4;
  logic signed [11:0] h5;
  logic signed [7:0]  h6;

  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];
  assign p1 = {1'b0, press_calib_a[15:0]};
  assign p2 = press_calib_a[31:16];
  assign p3 = press_calib_a[47:32];
  assign p4 = press_calib_a[63:48];
  assign p5 = press_calib_b[15:0];
  assign p6 = press_calib_b[31:16];
  assign p7 = press_calib_b[47:32];
  assign p8 = press_calib_b[63:48];
  assign p9 = press_calib_c;
  assign h1 = {1'b0, hum_calib_a[7:0]};
  assign h2 = hum_calib_a[23:8];
  assign h3 = {1'b0, hum_calib_a[31:24]};
  assign h4 = 32'($signed(hum_calib_b[11:0]));
  assign h5 = hum_calib_b[23:12];
  assign h6 = hum_calib_b[31:24];

  assign busy = 1'b0;

  logic [csc_pkg::PreStages:1] pv;
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[csc_pkg::PreStages-1:1], start};
    end
  end

  logic [19:0] rp [1:9];
  logic [15:0] rh [1:4];
  logic signed [31:0] s1_a, s1_d, s2_ta, s2_dd, s3_ta, s3_m, s4_fine;

  always_ff @(posedge clk) begin
    rp[1] <= sample.raw_pressure;
    rh[1] <= sample.raw_humidity;
    for (int k = 2; k <= 9; k++) rp[k] <= rp[k-1];
    for (int k = 2; k <= 4; k++) rh[k] <= rh[k-1];
    s1_a <= $signed({15'b0, sample.raw_temperature[19:3]} - {15'b0, t1, 1'b0});
    s1_d <= $signed({16'b0, sample.raw_temperature[19:4]} - {16'b0, t1});
    s2_ta <= s1_a * t2;
    s2_dd <= s1_d * s1_d;
    s3_ta <= s2_ta;
    s3_m  <= (s2_dd >>> 12) * t3;
    s4_fine <= (s3_ta >>> 11) + (s3_m >>> 14);
  end

  logic signed [35:0] tx, ts;
  logic signed [15:0] temp_sat;
  assign tx = {{4{s4_fine[31]}}, s4_fine} * 36'sd5 + 36'sd128;
  assign ts = tx >>> 8;
  always_comb begin
    if (ts < -36'sd32768) begin
      temp_sat = 16'sh8000;
    end else if (ts > 36'sd32767) begin
      temp_sat = 16'sh7fff;
    end else begin
      temp_sat = ts[15:0];
    end
  end

  csc_pkg::side_t     sd [5:11];
  logic signed [33:0] s5_w1;
  logic signed [63:0] s6_ww, s6_m5, s6_m2, s7_w2a, s7_w1a, s7_m5, s7_m2;
  logic signed [63:0] s8_w2, s8_w1b, s9_w2, s9_w1c, s10_den, s10_num0;
  logic signed [63:0] s11_den, s11_num;
  logic signed [63:0] pp;

  assign pp = $signed({43'b0, 21'd1048576 - {1'b0, rp[9]}});

  always_ff @(posedge clk) begin
    sd[5].temperature_centi <= temp_sat;
    sd[5].hum_h             <= s4_fine - 32'sd76800;
    sd[5].raw_humidity      <= rh[4];
    for (int k = 6; k <= 11; k++) sd[k] <= sd[k-1];
    s5_w1   <= {{2{s4_fine[31]}}, s4_fine} - 34'sd128000;
    s6_ww   <= s5_w1 * s5_w1;
    s6_m5   <= s5_w1 * p5;
    s6_m2   <= s5_w1 * p2;
    s7_w2a  <= s6_ww * p6;
    s7_w1a  <= s6_ww * p3;
    s7_m5   <= s6_m5;
    s7_m2   <= s6_m2;
    s8_w2   <= s7_w2a + (s7_m5 <<< 17) + (64'(p4) <<< 35);
    s8_w1b  <= (s7_w1a >>> 8) + (s7_m2 <<< 12);
    s9_w2   <= s8_w2;
    s9_w1c  <= (64'sh0000_8000_0000_0000 + s8_w1b) * $signed(p1);
    s10_den <= s9_w1c >>> 33;
    s10_num0 <= (pp <<< 31) - s9_w2;
    s11_den <= s10_den;
    s11_num <= s10_num0 * 64'sd3125;
  end

  logic               q_valid, q_zero;
  logic signed [63:0] q_quot;
  csc_pkg::side_t     q_side;

  csc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pv[csc_pkg::PreStages]),
    .num       (s11_num),
    .den       (s11_den),
    .side_in   (sd[11]),
    .out_valid (q_valid),
    .quot      (q_quot),
    .zero      (q_zero),
    .side_out  (q_side)
  );

  logic [csc_pkg::PostStages:1] ov;
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= '0;
    end else begin
      ov <= {ov[csc_pkg::PostStages-1:1], q_valid};
    end
  end

  logic signed [15:0] tmp [1:csc_pkg::PostStages];
  logic               zr  [1:7];
  logic signed [63:0] e1_a13, e1_m8, e1_q, e2_b, e2_a13, e2_m8, e2_q;
  logic [63:0]        e3_ll;
  logic [31:0]        e3_lh, e3_hl;
  logic signed [63:0] e3_m8, e3_q, e4_prod, e4_w2, e4_q, e5_s, e6_pf;
  logic [31:0]        e7_p, e8_p, e9_p, e10_p;
  logic               e8_v, e9_v, e10_v;
  logic [63:0]        prod_sum;

  assign prod_sum = e3_ll + {e3_lh + e3_hl, 32'b0};

  always_ff @(posedge clk) begin
    tmp[1] <= q_side.temperature_centi;
    for (int k = 2; k <= csc_pkg::PostStages; k++) tmp[k] <= tmp[k-1];
    zr[1] <= q_zero;
    for (int k = 2; k <= 7; k++) zr[k] <= zr[k-1];
    e1_a13 <= q_quot >>> 13;
    e1_m8  <= q_quot * p8;
    e1_q   <= q_quot;
    e2_b   <= e1_a13 * p9;
    e2_a13 <= e1_a13;
    e2_m8  <= e1_m8;
    e2_q   <= e1_q;
    e3_ll  <= {32'b0, e2_b[31:0]} * {32'b0, e2_a13[31:0]};
    e3_lh  <= e2_b[31:0] * e2_a13[63:32];
    e3_hl  <= e2_b[63:32] * e2_a13[31:0];
    e3_m8  <= e2_m8;
    e3_q   <= e2_q;
    e4_prod <= $signed(prod_sum);
    e4_w2   <= e3_m8 >>> 19;
    e4_q    <= e3_q;
    e5_s    <= e4_q + (e4_prod >>> 25) + e4_w2;
    e6_pf   <= (e5_s >>> 8) + (64'(p7) <<< 4);
    if (zr[6] || e6_pf < 64'sd0) begin
      e7_p <= '0;
    end else if (e6_pf > 64'sh0000_0000_FFFF_FFFF) begin
      e7_p <= '1;
    end else begin
      e7_p <= e6_pf[31:0];
    end
    e8_p  <= e7_p;
    e9_p  <= e8_p;
    e10_p <= e9_p;
    e8_v  <= !zr[7];
    e9_v  <= e8_v;
    e10_v <= e9_v;
  end

  logic signed [31:0] h1_x0, h1_m6, h1_m3, h2_x, h2_ya, h2_yb, h3_x, h3_yc;
  logic signed [31:0] h4_x, h4_y, h5_x, h5_yd, h6_x, h6_y2, h7_hh, h8_hh, h8_sq;
  logic signed [31:0] h9_hh, h9_u, hum_r;
  logic [16:0]        h10_hum;

  always_comb begin
    hum_r = h9_hh - (h9_u >>> 4);
    if (hum_r < 32'sd0) begin
      hum_r = '0;
    end else if (hum_r > 32'sd419430400) begin
      hum_r = 32'sd419430400;
    end
  end

  always_ff @(posedge clk) begin
    h1_x0 <= $signed({2'b0, q_side.raw_humidity, 14'b0}) - (h4 <<< 20)
             - h5 * q_side.hum_h + 32'sd16384;
    h1_m6 <= q_side.hum_h * h6;
    h1_m3 <= q_side.hum_h * $signed(h3);
    h2_x  <= h1_x0 >>> 15;
    h2_ya <= h1_m6 >>> 10;
    h2_yb <= (h1_m3 >>> 11) + 32'sd32768;
    h3_x  <= h2_x;
    h3_yc <= h2_ya * h2_yb;
    h4_x  <= h3_x;
    h4_y  <= (h3_yc >>> 10) + 32'sd2097152;
    h5_x  <= h4_x;
    h5_yd <= h4_y * h2 + 32'sd8192;
    h6_x  <= h5_x;
    h6_y2 <= h5_yd >>> 14;
    h7_hh <= h6_x * h6_y2;
    h8_hh <= h7_hh;
    h8_sq <= (h7_hh >>> 15) * (h7_hh >>> 15);
    h9_hh <= h8_hh;
    h9_u  <= (h8_sq >>> 7) * $signed(h1);
    h10_hum <= hum_r[28:12];
  end

  assign done                     = ov[csc_pkg::PostStages];
  assign result.temperature_centi = tmp[csc_pkg::PostStages];
  assign result.pressure_q24_8    = e10_p;
  assign result.pressure_valid    = e10_v;
  assign result.humidity_q22_10   = h10_hum;

  assert property (@(posedge clk) disable iff (rst)
    start |-> ##(csc_pkg::PipeLatency) done)
    else $error("result missing after the pipeline latency");

  assert property (@(posedge clk) disable iff (rst)
    done |-> result.humidity_q22_10 <= 17'd102400)
    else $error("humidity above the clamp");

  assert property (@(posedge clk) disable iff (rst)
    (done && !result.pressure_valid) |-> result.pressure_q24_8 == '0)
    else $error("invalid pressure not forced to zero");

endmodule
